>>> src/cgl_pkg.sv
// Shared types, codes and constants for the cell grid block.
package cgl_pkg;

  localparam int MAX_COLS    = 128;
  localparam int MAX_ROWS    = 16;
  localparam int SCROLL_ROWS = 2;
  localparam int CELL_DEPTH  = MAX_COLS * MAX_ROWS;
  localparam int PAIR_DEPTH  = MAX_COLS * SCROLL_ROWS;
  localparam int CELL_AW     = $clog2(CELL_DEPTH);
  localparam int PAIR_AW     = $clog2(PAIR_DEPTH);
  localparam int CNT_W       = CELL_AW + 1;

  // Request actions
  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_TICK  = 3'd2;
  localparam logic [2:0] ACT_LIFE  = 3'd3;
  localparam logic [2:0] ACT_UP    = 3'd4;
  localparam logic [2:0] ACT_DOWN  = 3'd5;

  // Animation modes
  localparam logic [2:0] MODE_UP    = 3'd1;
  localparam logic [2:0] MODE_RIGHT = 3'd2;
  localparam logic [2:0] MODE_DOWN  = 3'd3;
  localparam logic [2:0] MODE_LEFT  = 3'd4;
  localparam logic [2:0] MODE_LIFE  = 3'd5;

  // Register indexes
  localparam logic [2:0] REG_COLUMNS   = 3'd0;
  localparam logic [2:0] REG_ROWS      = 3'd1;
  localparam logic [2:0] REG_ANIM_MODE = 3'd2;
  localparam logic [2:0] REG_SKIP      = 3'd3;
  localparam logic [2:0] REG_THRESHOLD = 3'd4;
  localparam logic [2:0] REG_FULL      = 3'd5;

  // Neighbor sequence steps: 0..7 neighbors, 8 the cell itself, 9 decide
  localparam logic [3:0] NB_SELF   = 4'd8;
  localparam logic [3:0] NB_DECIDE = 4'd9;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ,
    ST_SNAP_RD, ST_SNAP_WR, ST_NB,
    ST_SAVE_RD, ST_SAVE_WR, ST_MOVE_RD, ST_MOVE_WR, ST_BACK_RD, ST_BACK_WR
  } state_t;

  typedef struct packed {
    state_t phase;
    logic   accept;
    logic   emit;
    logic   cnt_inc;
    logic   cnt_clr;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic nb_end;
    logic out_free;
    logic tick_scroll;
    logic tick_life;
  } stat_t;

  // Row offset of neighbor step: -1, 0 or +1
  function automatic logic [1:0] nb_dj(input logic [2:0] k);
    case (k)
      3'd0, 3'd1, 3'd2: nb_dj = 2'b11;
      3'd3, 3'd4:       nb_dj = 2'b00;
      default:          nb_dj = 2'b01;
    endcase
  endfunction

  // Column offset of neighbor step
  function automatic logic [1:0] nb_dk(input logic [2:0] k);
    case (k)
      3'd0, 3'd3, 3'd5: nb_dk = 2'b11;
      3'd1, 3'd6:       nb_dk = 2'b00;
      default:          nb_dk = 2'b01;
    endcase
  endfunction

endpackage

>>> src/cgl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/cgl_ctrl.sv
// Sequencer for clearing, requests, Life generations and scrolls.
module cgl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [2:0]     action,
  input  cgl_pkg::stat_t stat,
  output cgl_pkg::cmd_t  cmd
);

  cgl_pkg::state_t state, state_next;
  logic            acc;
  logic            go_life;
  logic            go_scroll;

  assign in_ready  = (state == cgl_pkg::ST_IDLE) && stat.out_free;
  assign acc       = in_ready && in_valid;
  assign go_life   = (action == cgl_pkg::ACT_LIFE) ||
                     ((action == cgl_pkg::ACT_TICK) && stat.tick_life);
  assign go_scroll = (action == cgl_pkg::ACT_UP) || (action == cgl_pkg::ACT_DOWN) ||
                     ((action == cgl_pkg::ACT_TICK) && stat.tick_scroll);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgl_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      cgl_pkg::ST_CLEAR:   if (stat.last) state_next = cgl_pkg::ST_IDLE;
      cgl_pkg::ST_IDLE: begin
        if (acc) begin
          if (action == cgl_pkg::ACT_READ) state_next = cgl_pkg::ST_READ;
          else if (go_life)                state_next = cgl_pkg::ST_SNAP_RD;
          else if (go_scroll)              state_next = cgl_pkg::ST_SAVE_RD;
        end
      end
      cgl_pkg::ST_READ:    state_next = cgl_pkg::ST_IDLE;
      cgl_pkg::ST_SNAP_RD: state_next = cgl_pkg::ST_SNAP_WR;
      cgl_pkg::ST_SNAP_WR: state_next = stat.last ? cgl_pkg::ST_NB : cgl_pkg::ST_SNAP_RD;
      cgl_pkg::ST_NB:      if (stat.nb_end && stat.last) state_next = cgl_pkg::ST_IDLE;
      cgl_pkg::ST_SAVE_RD: state_next = cgl_pkg::ST_SAVE_WR;
      cgl_pkg::ST_SAVE_WR: state_next = stat.last ? cgl_pkg::ST_MOVE_RD : cgl_pkg::ST_SAVE_RD;
      cgl_pkg::ST_MOVE_RD: state_next = cgl_pkg::ST_MOVE_WR;
      cgl_pkg::ST_MOVE_WR: state_next = stat.last ? cgl_pkg::ST_BACK_RD : cgl_pkg::ST_MOVE_RD;
      cgl_pkg::ST_BACK_RD: state_next = cgl_pkg::ST_BACK_WR;
      cgl_pkg::ST_BACK_WR: state_next = stat.last ? cgl_pkg::ST_IDLE : cgl_pkg::ST_BACK_RD;
      default:             state_next = cgl_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd         = '0;
    cmd.phase   = state;
    cmd.accept  = acc;
    case (state)
      cgl_pkg::ST_CLEAR: begin
        cmd.cnt_inc = 1'b1;
        cmd.cnt_clr = stat.last;
      end
      cgl_pkg::ST_IDLE: begin
        cmd.emit = acc && (action != cgl_pkg::ACT_READ) && !go_life && !go_scroll;
      end
      cgl_pkg::ST_READ: cmd.emit = 1'b1;
      cgl_pkg::ST_SNAP_WR, cgl_pkg::ST_SAVE_WR, cgl_pkg::ST_MOVE_WR: begin
        cmd.cnt_inc = 1'b1;
        cmd.cnt_clr = stat.last;
      end
      cgl_pkg::ST_BACK_WR: begin
        cmd.cnt_inc = 1'b1;
        cmd.cnt_clr = stat.last;
        cmd.emit    = stat.last;
      end
      cgl_pkg::ST_NB: begin
        cmd.cnt_inc = stat.nb_end;
        cmd.cnt_clr = stat.nb_end && stat.last;
        cmd.emit    = stat.nb_end && stat.last;
      end
      default: cmd.cnt_inc = 1'b0;
    endcase
  end

endmodule

>>> src/cgl_dp.sv
// Datapath: configuration, cell store, snapshot, row buffer and result register.
module cgl_dp (
  input  logic           clk,
  input  logic           rst,
  input  cgl_pkg::cmd_t  cmd,
  output cgl_pkg::stat_t stat,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  input  logic [2:0]     action,
  input  logic [10:0]    cell_index,
  input  logic [7:0]     level,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     read_level,
  output logic           animated
);

  localparam int CW = cgl_pkg::CNT_W;
  localparam int AW = cgl_pkg::CELL_AW;
  localparam int PW = cgl_pkg::PAIR_AW;

  logic [7:0] columns, frame_skip, live_threshold, full_level, tick_phase;
  logic [4:0] rows;
  logic [2:0] anim_mode;

  logic [7:0]    cols;
  logic [4:0]    nrows;
  logic [CW-1:0] n, shift, lim, cnt;
  logic [3:0]    nb, count;
  logic          rv, dir_up, idx_ok_q, anim_q;

  logic          cell_we, snap_we, pair_we;
  logic [AW-1:0] cell_wa, cell_ra, snap_wa, snap_ra;
  logic [7:0]    cell_wd, cell_q, pair_q;
  logic [1:0]    snap_wd, snap_q;
  logic [PW-1:0] pair_ra;

  logic          idx_ok, tick_run, anim_now;
  logic [7:0]    sat_level;
  logic [CW-1:0] mv_src, mv_dst, tail;
  logic [CW+1:0] pos, row_off;
  logic [1:0]    dj, dk;
  logic          pos_ok;

  // Clamped geometry
  always_comb begin
    cols  = (columns == 8'd0) ? 8'd1 :
            (columns > 8'(cgl_pkg::MAX_COLS)) ? 8'(cgl_pkg::MAX_COLS) : columns;
    nrows = (rows < 5'd3) ? 5'd3 :
            (rows > 5'(cgl_pkg::MAX_ROWS)) ? 5'(cgl_pkg::MAX_ROWS) : rows;
    n     = CW'(cols) * CW'(nrows);
    shift = CW'(cols) * CW'(cgl_pkg::SCROLL_ROWS);
    tail  = n - shift;
  end

  // Request decode
  assign idx_ok    = {1'b0, cell_index} < n;
  assign sat_level = (level > full_level) ? full_level : level;
  assign tick_run  = (tick_phase == 8'd0);
  assign anim_now  = (action == cgl_pkg::ACT_TICK) && tick_run &&
                     (anim_mode inside {cgl_pkg::MODE_UP, cgl_pkg::MODE_RIGHT,
                                        cgl_pkg::MODE_DOWN, cgl_pkg::MODE_LEFT,
                                        cgl_pkg::MODE_LIFE});

  // Neighbor position, linear index with row stride
  always_comb begin
    dj      = cgl_pkg::nb_dj(nb[2:0]);
    dk      = cgl_pkg::nb_dk(nb[2:0]);
    row_off = (dj == 2'b01) ? (CW+2)'(cols) :
              (dj == 2'b11) ? (CW+2)'(0) - (CW+2)'(cols) : '0;
    pos     = (CW+2)'(cnt) + row_off + {{CW{dk[1]}}, dk};
    pos_ok  = !pos[CW+1] && (pos[CW-1:0] < n) && !pos[CW];
  end

  // Scroll addresses
  always_comb begin
    mv_dst = dir_up ? cnt : n - CW'(1) - cnt;
    mv_src = dir_up ? cnt + shift : mv_dst - shift;
  end

  // Per-phase loop length
  always_comb begin
    case (cmd.phase)
      cgl_pkg::ST_CLEAR:                         lim = CW'(cgl_pkg::CELL_DEPTH);
      cgl_pkg::ST_SAVE_WR, cgl_pkg::ST_BACK_WR: lim = shift;
      cgl_pkg::ST_MOVE_WR:                       lim = tail;
      default:                                   lim = n;
    endcase
  end

  assign stat.last        = (cnt == lim - CW'(1));
  assign stat.nb_end      = (nb == cgl_pkg::NB_DECIDE);
  assign stat.out_free    = !out_valid || out_ready;
  assign stat.tick_scroll = tick_run &&
                            ((anim_mode == cgl_pkg::MODE_UP) || (anim_mode == cgl_pkg::MODE_DOWN));
  assign stat.tick_life   = tick_run && (anim_mode == cgl_pkg::MODE_LIFE);

  // Memory port steering
  always_comb begin
    cell_we = 1'b0;
    cell_wa = cnt[AW-1:0];
    cell_wd = '0;
    cell_ra = cnt[AW-1:0];
    snap_we = 1'b0;
    snap_wa = cnt[AW-1:0];
    snap_wd = {cell_q > live_threshold, cell_q < live_threshold};
    snap_ra = cnt[AW-1:0];
    pair_we = 1'b0;
    pair_ra = cnt[PW-1:0];
    case (cmd.phase)
      cgl_pkg::ST_CLEAR: cell_we = 1'b1;
      cgl_pkg::ST_IDLE: begin
        cell_ra = cell_index;
        cell_wa = cell_index;
        cell_wd = sat_level;
        cell_we = cmd.accept && (action == cgl_pkg::ACT_WRITE) && idx_ok;
      end
      cgl_pkg::ST_SNAP_WR: snap_we = 1'b1;
      cgl_pkg::ST_NB: begin
        if (nb < cgl_pkg::NB_SELF) snap_ra = pos[AW-1:0];
        if (nb == cgl_pkg::NB_DECIDE) begin
          if (snap_q[1] && (count != 4'd2) && (count != 4'd3)) begin
            cell_we = 1'b1;
          end else if (snap_q[0] && (count == 4'd3)) begin
            cell_we = 1'b1;
            cell_wd = full_level;
          end
        end
      end
      cgl_pkg::ST_SAVE_RD: cell_ra = dir_up ? cnt[AW-1:0] : AW'(tail + cnt);
      cgl_pkg::ST_SAVE_WR: pair_we = 1'b1;
      cgl_pkg::ST_MOVE_RD: cell_ra = mv_src[AW-1:0];
      cgl_pkg::ST_MOVE_WR: begin
        cell_we = 1'b1;
        cell_wa = mv_dst[AW-1:0];
        cell_wd = cell_q;
      end
      cgl_pkg::ST_BACK_WR: begin
        cell_we = 1'b1;
        cell_wa = dir_up ? AW'(tail + cnt) : cnt[AW-1:0];
        cell_wd = pair_q;
      end
      default: cell_we = 1'b0;
    endcase
  end

  cgl_ram #(.WIDTH(8), .DEPTH(cgl_pkg::CELL_DEPTH)) u_cells (
    .clk(clk), .we(cell_we), .waddr(cell_wa), .wdata(cell_wd),
    .raddr(cell_ra), .rdata(cell_q)
  );

  cgl_ram #(.WIDTH(2), .DEPTH(cgl_pkg::CELL_DEPTH)) u_snap (
    .clk(clk), .we(snap_we), .waddr(snap_wa), .wdata(snap_wd),
    .raddr(snap_ra), .rdata(snap_q)
  );

  cgl_ram #(.WIDTH(8), .DEPTH(cgl_pkg::PAIR_DEPTH)) u_pair (
    .clk(clk), .we(pair_we), .waddr(cnt[PW-1:0]), .wdata(cell_q),
    .raddr(pair_ra), .rdata(pair_q)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      columns        <= 8'd88;
      rows           <= 5'd13;
      anim_mode      <= 3'd0;
      frame_skip     <= 8'd0;
      live_threshold <= 8'd100;
      full_level     <= 8'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        cgl_pkg::REG_COLUMNS:   columns        <= cfg_data;
        cgl_pkg::REG_ROWS:      rows           <= cfg_data[4:0];
        cgl_pkg::REG_ANIM_MODE: anim_mode      <= cfg_data[2:0];
        cgl_pkg::REG_SKIP:      frame_skip     <= cfg_data;
        cgl_pkg::REG_THRESHOLD: live_threshold <= cfg_data;
        cgl_pkg::REG_FULL:      full_level     <= cfg_data;
        default:                columns        <= columns;
      endcase
    end
  end

  // Loop counter, tick phase and neighbor sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      tick_phase <= '0;
      nb         <= '0;
      count      <= '0;
      rv         <= 1'b0;
    end else begin
      if (cmd.cnt_clr)      cnt <= '0;
      else if (cmd.cnt_inc) cnt <= cnt + CW'(1);

      if (cmd.accept && (action == cgl_pkg::ACT_TICK)) begin
        tick_phase <= (tick_phase >= frame_skip) ? 8'd0 : tick_phase + 8'd1;
      end

      if (cmd.phase == cgl_pkg::ST_NB) begin
        if (nb == cgl_pkg::NB_DECIDE) begin
          nb    <= '0;
          count <= '0;
        end else begin
          nb <= nb + 4'd1;
          rv <= (nb < cgl_pkg::NB_SELF) ? pos_ok : 1'b1;
          if (nb != 4'd0) count <= count + {3'd0, rv & snap_q[1]};
        end
      end else begin
        nb    <= '0;
        count <= '0;
      end
    end
  end

  // Per-request flags
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_ok_q <= idx_ok;
      anim_q   <= anim_now;
      dir_up   <= (action == cgl_pkg::ACT_UP) ||
                  ((action == cgl_pkg::ACT_TICK) && (anim_mode == cgl_pkg::MODE_UP));
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      read_level <= ((cmd.phase == cgl_pkg::ST_READ) && idx_ok_q) ? cell_q : 8'd0;
      animated   <= (cmd.phase == cgl_pkg::ST_IDLE) ? anim_now : anim_q;
    end
  end

endmodule

>>> src/cell_grid_life_and_scroll.sv
// Top level of the cell grid block: Life generations and row scrolling.
//
// Requests arrive on in_valid/in_ready with action, cell_index and level;
// each request yields exactly one result on out_valid/out_ready carrying
// read_level and animated. Registers are written through cfg_we, cfg_index
// and cfg_data; the user is to write them only while the block is idle,
// which the block itself does not enforce. A read passes through a read
// state; a Life generation snapshots every cell, then steps through each
// cell's neighbors; a scroll saves two rows, moves the rest and writes
// them back; the cell store has a single read and a single write port.
// One request is worked on at a time; the next one is taken once the
// current result is loaded and the result register is free or being drained.
// After reset the block clears its 2048-entry cell store, one entry per
// cycle, and accepts no request until the clear is done.
// A stalled receiver holds the result register and so holds off new requests.
module cell_grid_life_and_scroll (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [10:0] cell_index,
  input  logic [7:0]  level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_level,
  output logic        animated
);

  cgl_pkg::cmd_t  cmd;
  cgl_pkg::stat_t stat;

  cgl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .stat(stat), .cmd(cmd)
  );

  cgl_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .action(action), .cell_index(cell_index), .level(level),
    .out_valid(out_valid), .out_ready(out_ready),
    .read_level(read_level), .animated(animated)
  );

endmodule
